[hw/rtl/ctu_pkg.sv]
package ctu_pkg;

   localparam int CODE_W   = 64;
   localparam int TARGET_W = 4;

   localparam logic [CODE_W-1:0] CODE_ADMIN_DEFAULT = 64'h3837_3635_3433_3231;
   localparam logic [CODE_W-1:0] CODE_USER_DEFAULT  = 64'h3030_3030_3030_3030;
   localparam logic [7:0]        BYTE_ERASED        = 8'hFF;

   typedef enum logic [1:0] {
      OP_AUTH   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CHANGE = 2'd3
   } op_type;

   localparam logic [1:0] ROLE_NONE  = 2'd0;
   localparam logic [1:0] ROLE_ADMIN = 2'd1;
   localparam logic [1:0] ROLE_USER  = 2'd2;

   typedef struct packed {
      logic [1:0]          op;
      logic [CODE_W-1:0]   code_bytes;
      logic                role_admin;
      logic [TARGET_W-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [1:0]          found_role;
      logic [TARGET_W-1:0] slot_used;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic                role_admin;
      logic [TARGET_W-1:0] target_slot;
      logic                len_ok;
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic                hit;
      logic                admin;
      logic [TARGET_W-1:0] slot;
   } token_type;

   // Keeps the bytes before the first zero byte and clears the rest.
   function automatic logic [CODE_W-1:0] canon_code(input logic [CODE_W-1:0] c);
      logic                keep;
      logic [CODE_W-1:0]   r;
      keep = 1'b1;
      r    = '0;
      for (int b = 0; b < CODE_W / 8; b++) begin
         keep = keep & (c[8*b +: 8] != 8'd0);
         if (keep) begin
            r[8*b +: 8] = c[8*b +: 8];
         end
      end
      return r;
   endfunction

   function automatic logic lead_len_ok(input logic [CODE_W-1:0] c);
      return (c[7:0] != 8'd0) && (c[15:8] != 8'd0) &&
             (c[23:16] != 8'd0) && (c[31:24] != 8'd0);
   endfunction

endpackage

[hw/rtl/ctu_cell.sv]
module ctu_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  ctu_pkg::cmd_type   cmd,
   input  ctu_pkg::token_type prev_tok,
   output ctu_pkg::token_type tok_out
);

   localparam logic [ctu_pkg::CODE_W-1:0] RESET_CODE =
      (CELL_INDEX == 0) ? ctu_pkg::CODE_ADMIN_DEFAULT :
      (CELL_INDEX == 1) ? ctu_pkg::CODE_USER_DEFAULT  : '0;
   localparam logic RESET_ADMIN = (CELL_INDEX == 0);
   localparam logic RESET_NAMED = (CELL_INDEX < 2);
   localparam logic ADDRESSABLE = (CELL_INDEX < (1 << ctu_pkg::TARGET_W));
   localparam logic [ctu_pkg::TARGET_W-1:0] CELL_LOW = ctu_pkg::TARGET_W'(CELL_INDEX);

   logic [ctu_pkg::CODE_W-1:0] code_ff, code_in;
   logic                       admin_ff, admin_in;
   logic                       named_ff, named_in;
   ctu_pkg::token_type         tok_ff, tok_in;

   logic [7:0] first_byte;
   logic       is_target;
   logic       owner_ok;
   logic       take;

   always_comb begin
      first_byte = code_ff[7:0];
      is_target  = ADDRESSABLE && (cmd.target_slot == CELL_LOW);
      owner_ok   = named_ff && (admin_ff == cmd.role_admin);
      code_in    = code_ff;
      admin_in   = admin_ff;
      named_in   = named_ff;
      tok_in     = prev_tok;
      take       = 1'b0;
      if (prev_tok.valid && !prev_tok.hit) begin
         case (cmd.op)
            ctu_pkg::OP_AUTH: begin
               if ((first_byte != 8'd0) && (first_byte != ctu_pkg::BYTE_ERASED) &&
                   (code_ff == cmd.code)) begin
                  take         = 1'b1;
                  tok_in.admin = admin_ff;
               end
            end
            ctu_pkg::OP_ADD: begin
               if (first_byte == 8'd0) begin
                  take     = 1'b1;
                  code_in  = cmd.code;
                  admin_in = cmd.role_admin;
                  named_in = 1'b1;
               end
            end
            ctu_pkg::OP_REMOVE: begin
               if (is_target && owner_ok) begin
                  take     = 1'b1;
                  code_in  = '0;
                  admin_in = 1'b0;
                  named_in = 1'b0;
               end
            end
            ctu_pkg::OP_CHANGE: begin
               if (is_target && owner_ok && cmd.len_ok) begin
                  take    = 1'b1;
                  code_in = cmd.code;
               end
            end
            default: begin
               take = 1'b0;
            end
         endcase
      end
      if (take) begin
         tok_in.hit  = 1'b1;
         tok_in.slot = CELL_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= RESET_CODE;
         admin_ff <= RESET_ADMIN;
         named_ff <= RESET_NAMED;
         tok_ff   <= '0;
      end else begin
         code_ff  <= code_in;
         admin_ff <= admin_in;
         named_ff <= named_in;
         tok_ff   <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

[hw/rtl/credential_table_unit.sv]
// Table of SLOT_COUNT access codes with authenticate, add, remove and change operations.
// A word is taken when start is high while busy is low; busy then stays high until the
// result has been shown. Each slot lives in its own cell, and a request token walks the
// row of cells one cell per clock: a word passes the launch register and then the
// register of each cell, and the result is shown from the last cell; no new word is
// taken before that. The result appears on rsp_word for exactly one cycle with
// rsp_strobe high and must be taken then, since the receiver cannot hold it off.
module credential_table_unit #(
   parameter int SLOT_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ctu_pkg::req_type req_word,
   output logic             rsp_strobe,
   output ctu_pkg::rsp_type rsp_word
);

   logic               busy_ff, busy_in;
   ctu_pkg::cmd_type   cmd_ff, cmd_in;
   ctu_pkg::token_type launch_ff, launch_in;
   ctu_pkg::token_type tokens [SLOT_COUNT+1];
   ctu_pkg::token_type last_tok;
   logic [SLOT_COUNT:0] tok_valid;
   logic               accept;

   assign accept = start && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_strobe) begin
         busy_in = 1'b0;
      end
      cmd_in = cmd_ff;
      if (accept) begin
         cmd_in.op          = ctu_pkg::op_type'(req_word.op);
         cmd_in.code        = ctu_pkg::canon_code(req_word.code_bytes);
         cmd_in.role_admin  = req_word.role_admin;
         cmd_in.target_slot = req_word.target_slot;
         cmd_in.len_ok      = ctu_pkg::lead_len_ok(req_word.code_bytes);
      end
      launch_in       = '0;
      launch_in.valid = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         launch_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         launch_ff <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign tokens[0]    = launch_ff;
   assign tok_valid[0] = launch_ff.valid;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      ctu_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .prev_tok (tokens[i]),
         .tok_out  (tokens[i+1])
      );
      assign tok_valid[i+1] = tokens[i+1].valid;
   end

   always_comb begin
      last_tok            = tokens[SLOT_COUNT];
      rsp_strobe          = last_tok.valid;
      rsp_word.ok         = last_tok.hit;
      rsp_word.found_role = ctu_pkg::ROLE_NONE;
      if (last_tok.hit && (cmd_ff.op == ctu_pkg::OP_AUTH)) begin
         rsp_word.found_role = last_tok.admin ? ctu_pkg::ROLE_ADMIN : ctu_pkg::ROLE_USER;
      end
      rsp_word.slot_used = last_tok.hit ? last_tok.slot : '0;
   end

   assign busy = busy_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one request token in the cell row");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(SLOT_COUNT + 1) rsp_strobe)
      else $error("result did not arrive after the walk of the row");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_valid != '0) |-> busy_ff)
      else $error("request token in flight while not busy");

   a_role_auth_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (cmd_ff.op != ctu_pkg::OP_AUTH)) |->
         (rsp_word.found_role == ctu_pkg::ROLE_NONE))
      else $error("role reported for an operation other than authenticate");

endmodule
